// File: rtl/dbcd_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the CRC byte step for the display block change detector.
// No dependencies; every other file imports this package.
package dbcd_pkg;

   localparam int DEF_COLUMNS   = 128;
   localparam int DEF_PAGES     = 16;
   localparam int DEF_BLOCK_LEN = 16;

   // Column field is 7 bits, block length at least 2: at most 64 blocks, offsets up to 63.
   localparam int COL_W   = 7;
   localparam int BLKNR_W = 6;
   localparam int OFS_W   = 6;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'h1021;
   localparam logic [15:0] CRC_TOP  = 16'h8000;

   typedef struct packed {
      logic [7:0]       pixel_byte;
      logic [3:0]       page_index;
      logic [COL_W-1:0] column_index;
   } req_type;

   typedef struct packed {
      logic [3:0]  out_page;
      logic [2:0]  out_block;
      logic [15:0] block_checksum;
      logic        block_changed;
   } rsp_type;

   // Finished-block summary from the accumulator to the table stage.
   typedef struct packed {
      logic               last;
      logic [3:0]         page;
      logic [BLKNR_W-1:0] block;
      logic [15:0]        sum;
   } blk_info_type;

   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
         if ((c & CRC_TOP) != 16'h0000) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

// File: rtl/dbcd_accum.sv
`timescale 1ns / 1ps
// Running CRC-16 and XOR mix over the bytes of one block; flags the block's last byte.
// Depends on dbcd_pkg.
module dbcd_accum #(
   parameter int BLOCK_LEN = dbcd_pkg::DEF_BLOCK_LEN
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   fire,
   input  dbcd_pkg::req_type      req,
   input  logic                   color_mode,
   output dbcd_pkg::blk_info_type info
);
   import dbcd_pkg::*;

   localparam int COL_SPAN   = 1 << COL_W;
   localparam int COL_BLOCKS = (COL_SPAN + BLOCK_LEN - 1) / BLOCK_LEN;

   logic [15:0]        crc_ff, crc_in;
   logic [7:0]         xor_ff, xor_in;
   logic [BLKNR_W-1:0] block;
   logic [OFS_W-1:0]   offset;
   logic               first;
   logic               last;
   logic [7:0]         mix;
   logic [15:0]        crc_new;
   logic [7:0]         xor_new;

   // Locate the block by range compares against constant bounds.
   always_comb begin
      block  = '0;
      offset = '0;
      for (int b = 0; b < COL_BLOCKS; b++) begin
         if (int'(req.column_index) >= b * BLOCK_LEN &&
             int'(req.column_index) < (b + 1) * BLOCK_LEN) begin
            block  = BLKNR_W'(b);
            offset = OFS_W'(int'(req.column_index) - b * BLOCK_LEN);
         end
      end
   end

   assign first   = (offset == '0);
   assign last    = (offset == OFS_W'(BLOCK_LEN - 1));
   assign mix     = {1'b0, req.column_index} + {7'b0, color_mode};
   assign crc_new = crc_byte(first ? CRC_INIT : crc_ff, req.pixel_byte);
   assign xor_new = (first ? 8'h00 : xor_ff) ^ req.pixel_byte ^ mix;

   always_comb begin
      crc_in = crc_ff;
      xor_in = xor_ff;
      if (fire) begin
         crc_in = last ? CRC_INIT : crc_new;
         xor_in = last ? 8'h00 : xor_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff <= CRC_INIT;
         xor_ff <= 8'h00;
      end else begin
         crc_ff <= crc_in;
         xor_ff <= xor_in;
      end
   end

   assign info.last  = last;
   assign info.page  = req.page_index;
   assign info.block = block;
   assign info.sum   = crc_new ^ {xor_new, 8'h00};

endmodule

// File: rtl/display_block_change_detector.sv
`timescale 1ns / 1ps
// A block's last byte is registered in stage 1 (table read), then compared into the output register.
// Throughput: one byte per cycle unless the output stalls; the accumulator fold and table read/write port keep pace.
// Reset: synchronous; afterwards the checksum table is cleared one entry per cycle, over all
// PAGES * (COLUMNS / BLOCK_LEN) entries (128 by default), with req_ready low meanwhile.
// color_mode resets to 1. Depends on dbcd_pkg and dbcd_accum.
module display_block_change_detector #(
   parameter int COLUMNS   = dbcd_pkg::DEF_COLUMNS,
   parameter int PAGES     = dbcd_pkg::DEF_PAGES,
   parameter int BLOCK_LEN = dbcd_pkg::DEF_BLOCK_LEN
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  dbcd_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output dbcd_pkg::rsp_type rsp_data,
   input  logic              csr_wr_en,
   input  logic              csr_wr_data
);
   import dbcd_pkg::*;

   localparam int NBLOCKS    = COLUMNS / BLOCK_LEN;
   localparam int TABLE_SIZE = PAGES * NBLOCKS;
   localparam int MEM_DEPTH  = (TABLE_SIZE < 2) ? 2 : TABLE_SIZE;
   localparam int IDX_W      = $clog2(MEM_DEPTH);

   logic               color_mode_ff;
   logic               req_fire;
   blk_info_type       info;
   logic               in_range;
   logic [IDX_W-1:0]   rd_idx;
   logic               rd_en;

   logic [15:0]        mem [MEM_DEPTH];
   logic [15:0]        rdata_ff;
   logic               mem_we;
   logic [IDX_W-1:0]   mem_wa;
   logic [15:0]        mem_wd;

   logic               clearing_ff, clearing_in;
   logic [IDX_W-1:0]   clr_cnt_ff, clr_cnt_in;

   logic               s1_valid_ff, s1_valid_in;
   logic [3:0]         s1_page_ff;
   logic [BLKNR_W-1:0] s1_block_ff;
   logic [15:0]        s1_sum_ff;
   logic               s1_hit_ff;
   logic [IDX_W-1:0]   s1_idx_ff;
   logic               s1_fwd_ff;
   logic [15:0]        s1_fwd_data_ff;
   logic               s1_go;
   logic [15:0]        stored;
   logic               changed;

   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff;

   assign s1_go     = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !clearing_ff && (!s1_valid_ff || s1_go);
   assign req_fire  = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         color_mode_ff <= 1'b1;
      end else if (csr_wr_en) begin
         color_mode_ff <= csr_wr_data;
      end
   end

   dbcd_accum #(
      .BLOCK_LEN(BLOCK_LEN)
   ) u_accum (
      .clock     (clock),
      .reset     (reset),
      .fire      (req_fire),
      .req       (req_data),
      .color_mode(color_mode_ff),
      .info      (info)
   );

   assign in_range = (int'(info.page) < PAGES) && (int'(info.block) < NBLOCKS);
   assign rd_idx   = IDX_W'(int'(info.page) * NBLOCKS + int'(info.block));
   assign rd_en    = req_fire && info.last && in_range;

   // Clearing pass after reset.
   always_comb begin
      clearing_in = clearing_ff;
      clr_cnt_in  = clr_cnt_ff;
      if (clearing_ff) begin
         clr_cnt_in = clr_cnt_ff + 1'b1;
         if (clr_cnt_ff == IDX_W'(MEM_DEPTH - 1)) begin
            clearing_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_cnt_ff  <= '0;
      end else begin
         clearing_ff <= clearing_in;
         clr_cnt_ff  <= clr_cnt_in;
      end
   end

   // Table write port: clearing pass or retiring block.
   always_comb begin
      mem_we = 1'b0;
      mem_wa = s1_idx_ff;
      mem_wd = s1_sum_ff;
      if (clearing_ff) begin
         mem_we = 1'b1;
         mem_wa = clr_cnt_ff;
         mem_wd = 16'h0000;
      end else if (s1_go && s1_hit_ff) begin
         mem_we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      if (rd_en) begin
         rdata_ff <= mem[rd_idx];
      end
   end

   // Stage 1: table read in flight.
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_fire && info.last) begin
         s1_valid_in = 1'b1;
      end else if (s1_go) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && info.last) begin
         s1_page_ff     <= info.page;
         s1_block_ff    <= info.block;
         s1_sum_ff      <= info.sum;
         s1_hit_ff      <= in_range;
         s1_idx_ff      <= rd_idx;
         // Forward the retiring write when it hits the entry read in the same cycle.
         s1_fwd_ff      <= s1_go && s1_hit_ff && (s1_idx_ff == rd_idx);
         s1_fwd_data_ff <= s1_sum_ff;
      end
   end

   assign stored  = s1_fwd_ff ? s1_fwd_data_ff : rdata_ff;
   assign changed = s1_hit_ff ? (stored != s1_sum_ff) : 1'b1;

   // Output register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s1_go) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go) begin
         rsp_data_ff.out_page       <= s1_page_ff;
         rsp_data_ff.out_block      <= s1_block_ff[2:0];
         rsp_data_ff.block_checksum <= s1_sum_ff;
         rsp_data_ff.block_changed  <= changed;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: rtl/dbcd_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the display block change detector, bound to the top level.
// Depends on dbcd_pkg and display_block_change_detector.
module dbcd_checker #(
   parameter int PAGES = dbcd_pkg::DEF_PAGES
) (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input dbcd_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input dbcd_pkg::rsp_type rsp_data
);
   import dbcd_pkg::*;

   // Hold a stalled result transaction unchanged.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed or dropped");

   // Hold a stalled input transaction unchanged.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_data))
      else $error("stalled input changed or dropped");

   // Table clearing starts right after reset: no input taken, no result pending.
   assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !req_ready && !rsp_valid)
      else $error("block active right after reset");

   // A page outside the table always reports a change.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (int'(rsp_data.out_page) >= PAGES) |-> rsp_data.block_changed)
      else $error("out-of-table page reported unchanged");

endmodule

bind display_block_change_detector dbcd_checker #(
   .PAGES(PAGES)
) u_dbcd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_valid),
   .req_ready  (req_ready),
   .req_data   (req_data),
   .rsp_valid  (rsp_valid),
   .rsp_ready  (rsp_ready),
   .rsp_data   (rsp_data)
);
